// ----- rtl/trs_pkg.sv -----
// Package for the thruster ramp sequencer: op codes, table selects, phases,
// field widths and the per-thruster state record. No dependencies.
package trs_pkg;

  localparam logic [1:0] OP_FIRE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_TABLE = 2'd2;

  localparam logic [1:0] SEL_ON   = 2'd0;
  localparam logic [1:0] SEL_OFF  = 2'd1;
  localparam logic [1:0] SEL_MISC = 2'd2;

  localparam logic [1:0] PH_OFF    = 2'd0;
  localparam logic [1:0] PH_ONRAMP = 2'd1;
  localparam logic [1:0] PH_STEADY = 2'd2;
  localparam logic [1:0] PH_OFFRMP = 2'd3;

  localparam logic [15:0] FULL_FACTOR = 16'd32768;

  typedef struct packed {
    logic [31:0] start_time;
    logic [31:0] on_command;
    logic [31:0] last_update;
    logic [31:0] on_elapsed;
    logic [31:0] off_elapsed;
    logic [31:0] steady_elapsed;
    logic [15:0] factor;
    logic [31:0] min_on;
    logic [3:0]  on_len;
    logic [3:0]  off_len;
  } thr_state_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ----- rtl/trs_if.sv -----
// Valid/ready channel interfaces for command input and thruster results.
// Depends on nothing.
interface trs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [2:0]  thruster;
  logic [31:0] on_time;
  logic [1:0]  table_sel;
  logic [2:0]  entry;
  logic [31:0] entry_time;
  logic [15:0] entry_factor;
  logic [3:0]  on_len;
  logic [3:0]  off_len;
  modport source (output valid, op, thruster, on_time, table_sel, entry, entry_time,
                  entry_factor, on_len, off_len, input ready);
  modport sink (input valid, op, thruster, on_time, table_sel, entry, entry_time,
                entry_factor, on_len, off_len, output ready);
endinterface

interface trs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  thruster_id;
  logic [15:0] thrust_factor;
  logic [1:0]  phase;
  logic        last;
  modport source (output valid, thruster_id, thrust_factor, phase, last, input ready);
  modport sink (input valid, thruster_id, thrust_factor, phase, last, output ready);
endinterface

// ----- rtl/thruster_ramp_sequencer.sv -----
// Thruster ramp sequencer top level: state memory, ramp table memories,
// read-modify-write sequencer. Depends on trs_pkg and trs_if.
//
// A fire command or table write reads the state memory, then in S_CMD writes
// the updated record back for a fire or a min-on and length write. A tick
// reads one thruster state record and its ramp table rows each cycle while
// the output is not stalled and writes the update back as the next record
// is read, the ramp entries of that thruster being compared in parallel.
// Results leave through a single output register; a stalled result holds the
// walk. The state memory comes out of reset through a clearing pass during which no item is accepted.
module thruster_ramp_sequencer #(
  parameter int THRUSTERS    = 8,
  parameter int RAMP_ENTRIES = 8
) (
  input logic    clk_i,
  input logic    rst_ni,
  trs_in_if.sink   in_i,
  trs_out_if.source out_o
);
  import trs_pkg::*;

  localparam int TW = (THRUSTERS > 1) ? $clog2(THRUSTERS) : 1;
  localparam int EW = (RAMP_ENTRIES > 1) ? $clog2(RAMP_ENTRIES) : 1;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CMD  = 3'd2;
  localparam logic [2:0] S_TICK = 3'd3;

  logic [2:0]  st_q, st_d;
  logic [TW:0] idx_q, idx_d;    // next thruster to read, or to clear
  logic [31:0] time_q, time_d;
  logic        rd_pend_q;        // registered read enable for the read at rd_idx_q
  logic [TW-1:0] rd_idx_q;

  // state memory
  thr_state_t mem [THRUSTERS];
  thr_state_t rd_q;
  logic          we;
  logic [TW-1:0] wa;
  thr_state_t    wd;
  logic          re;
  logic [TW-1:0] ra;

  // ramp tables, one row of entries per thruster
  logic [RAMP_ENTRIES-1:0][31:0] on_dl  [THRUSTERS];
  logic [RAMP_ENTRIES-1:0][15:0] on_fc  [THRUSTERS];
  logic [RAMP_ENTRIES-1:0][31:0] off_dl [THRUSTERS];
  logic [RAMP_ENTRIES-1:0][15:0] off_fc [THRUSTERS];
  logic [RAMP_ENTRIES-1:0][31:0] on_dl_rd_q, off_dl_rd_q;
  logic [RAMP_ENTRIES-1:0][15:0] on_fc_rd_q, off_fc_rd_q;

  // read the state record and the ramp rows of one thruster together
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) begin
      rd_q        <= mem[ra];
      on_dl_rd_q  <= on_dl[ra];
      on_fc_rd_q  <= on_fc[ra];
      off_dl_rd_q <= off_dl[ra];
      off_fc_rd_q <= off_fc[ra];
    end
  end

  // held command
  logic [1:0]  c_op_q, c_sel_q;
  logic [TW-1:0] c_t_q;
  logic [31:0] c_ont_q, c_et_q;
  logic [3:0]  c_ol_q, c_fl_q;
  logic        c_ok_q;

  logic in_ok, e_ok;
  assign in_ok = ({29'd0, in_i.thruster} < 32'(THRUSTERS));
  assign e_ok  = ({29'd0, in_i.entry} < 32'(RAMP_ENTRIES));
  assign in_i.ready = (st_q == S_IDLE);

  logic acc;
  assign acc = in_i.valid && in_i.ready;

  logic [15:0] fsat;
  assign fsat = (in_i.entry_factor > FULL_FACTOR) ? FULL_FACTOR : in_i.entry_factor;

  always_ff @(posedge clk_i) begin
    if (acc && in_i.op == OP_TABLE && in_ok && e_ok) begin
      if (in_i.table_sel == SEL_ON) begin
        on_dl[in_i.thruster[TW-1:0]][in_i.entry[EW-1:0]] <= in_i.entry_time;
        on_fc[in_i.thruster[TW-1:0]][in_i.entry[EW-1:0]] <= fsat;
      end else if (in_i.table_sel == SEL_OFF) begin
        off_dl[in_i.thruster[TW-1:0]][in_i.entry[EW-1:0]] <= in_i.entry_time;
        off_fc[in_i.thruster[TW-1:0]][in_i.entry[EW-1:0]] <= fsat;
      end
    end
    if (acc) begin
      c_op_q <= in_i.op; c_sel_q <= in_i.table_sel; c_t_q <= in_i.thruster[TW-1:0];
      c_ont_q <= in_i.on_time; c_et_q <= in_i.entry_time;
      c_ol_q <= in_i.on_len; c_fl_q <= in_i.off_len;
      c_ok_q <= in_ok;
    end
  end

  // output register
  logic        ov_q;
  logic [2:0]  oid_q;
  logic [15:0] of_q;
  logic [1:0]  oph_q;
  logic        ol_q;
  assign out_o.valid = ov_q;
  assign out_o.thruster_id = oid_q;
  assign out_o.thrust_factor = of_q;
  assign out_o.phase = oph_q;
  assign out_o.last = ol_q;

  logic out_free;
  assign out_free = !ov_q || out_o.ready;

  // update of one thruster on a tick
  thr_state_t up_st;
  logic [1:0] up_ph;

  always_comb begin
    logic [31:0] dt, loc;
    logic firing, hit;
    logic [15:0] hf;
    up_st = rd_q;
    up_ph = PH_OFF;
    dt = time_q - rd_q.last_update;
    firing = (rd_q.on_command != 32'd0) &&
             ((time_q - rd_q.start_time) <= rd_q.on_command);
    hit = 1'b0; hf = '0; loc = '0;
    if (firing) begin
      loc = sat_add(dt, rd_q.on_elapsed);
      for (int i = RAMP_ENTRIES-1; i >= 0; i--)
        if (32'(i) < {28'd0, rd_q.on_len} && loc < on_dl_rd_q[EW'(i)]) begin
          hit = 1'b1; hf = on_fc_rd_q[EW'(i)];
        end
      up_st.last_update = time_q;
      if (hit) begin
        up_st.factor = hf; up_st.on_elapsed = loc; up_ph = PH_ONRAMP;
      end else begin
        up_st.steady_elapsed = sat_add(rd_q.steady_elapsed, dt);
        up_st.factor = FULL_FACTOR; up_ph = PH_STEADY;
      end
    end else if (rd_q.factor != 16'd0) begin
      loc = sat_add(dt, rd_q.off_elapsed);
      for (int i = RAMP_ENTRIES-1; i >= 0; i--)
        if (32'(i) < {28'd0, rd_q.off_len} && loc < off_dl_rd_q[EW'(i)]) begin
          hit = 1'b1; hf = off_fc_rd_q[EW'(i)];
        end
      if (hit) begin
        up_st.factor = hf; up_st.off_elapsed = loc; up_st.last_update = time_q;
        up_ph = PH_OFFRMP;
      end else begin
        up_st.factor = '0;
      end
    end
  end

  // command update: fire, or min-on and length write
  thr_state_t cm_st;
  logic       cm_we;
  always_comb begin
    logic hit;
    logic [31:0] hd;
    cm_st = rd_q;
    cm_we = 1'b0;
    hit = 1'b0; hd = '0;
    for (int i = RAMP_ENTRIES-1; i >= 0; i--)
      if (32'(i) < {28'd0, rd_q.on_len} && on_fc_rd_q[EW'(i)] >= rd_q.factor) begin
        hit = 1'b1; hd = on_dl_rd_q[EW'(i)];
      end
    if (c_op_q == OP_FIRE && c_ont_q > rd_q.min_on) begin
      cm_we = c_ok_q;
      cm_st.start_time = time_q; cm_st.on_command = c_ont_q;
      cm_st.steady_elapsed = '0; cm_st.off_elapsed = '0;
      cm_st.last_update = time_q;
      cm_st.on_elapsed = (rd_q.factor != 16'd0 && hit) ? hd : 32'd0;
    end else if (c_op_q == OP_TABLE && c_sel_q == SEL_MISC) begin
      cm_we = c_ok_q;
      cm_st.min_on = c_et_q;
      cm_st.on_len = (c_ol_q > 4'(RAMP_ENTRIES)) ? 4'(RAMP_ENTRIES) : c_ol_q;
      cm_st.off_len = (c_fl_q > 4'(RAMP_ENTRIES)) ? 4'(RAMP_ENTRIES) : c_fl_q;
    end
  end

  logic adv;  // tick pipeline moves this cycle
  assign adv = (st_q == S_TICK) && out_free;

  always_comb begin
    st_d = st_q; idx_d = idx_q; time_d = time_q;
    we = 1'b0; wa = '0; wd = '0; re = 1'b0; ra = '0;
    unique case (st_q)
      S_CLR: begin
        we = 1'b1; wa = idx_q[TW-1:0];
        idx_d = idx_q + 1'b1;
        if (idx_q == (TW+1)'(THRUSTERS-1)) begin
          st_d = S_IDLE; idx_d = '0;
        end
      end
      S_IDLE: begin
        if (acc) begin
          if (in_i.op == OP_TICK) begin
            st_d = S_TICK; time_d = time_q + 32'd1;
            re = 1'b1; ra = '0; idx_d = (TW+1)'(1);
          end else begin
            st_d = S_CMD; re = 1'b1; ra = in_i.thruster[TW-1:0];
          end
        end
      end
      S_CMD: begin
        we = cm_we; wa = c_t_q; wd = cm_st; st_d = S_IDLE;
      end
      default: begin
        if (adv) begin
          we = 1'b1; wa = rd_idx_q; wd = up_st;
          if (idx_q == (TW+1)'(THRUSTERS)) begin
            st_d = S_IDLE; idx_d = '0;
          end else begin
            re = 1'b1; ra = idx_q[TW-1:0]; idx_d = idx_q + 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; idx_q <= '0; time_q <= '0; rd_pend_q <= 1'b0; rd_idx_q <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d; idx_q <= idx_d; time_q <= time_d;
      rd_pend_q <= re;
      if (re) rd_idx_q <= ra;
      if (adv) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
    end
  end

  // load a result as its state is written back
  always_ff @(posedge clk_i) begin
    if (adv) begin
      oid_q <= 3'(rd_idx_q); of_q <= up_st.factor; oph_q <= up_ph;
      ol_q  <= ({{(32-TW){1'b0}}, rd_idx_q} == 32'(THRUSTERS-1));
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_TICK) |-> rd_pend_q || $past(st_q == S_TICK))
    else $error("tick walk without pending read");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_o.ready) |=> ov_q && $stable(oid_q))
    else $error("stalled result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> !in_i.ready)
    else $error("input ready while busy");
endmodule
